// ----- src/pvd_pkg.sv -----
// ----------------------------------------------------------------------------
// pvd_pkg
// Shared widths, register indexes and the pipeline bundle of the polynomial
// value and derivatives unit.
// ----------------------------------------------------------------------------
package pvd_pkg;

	localparam int COEFF_COUNT_DEF = 6;

	localparam int X_W        = 32;  // abscissa, Q16.16
	localparam int COEF_W     = 32;  // coefficient, Q16.16
	localparam int ACC_W      = 48;  // accumulator and results, Q32.16
	localparam int FRAC_W     = 16;
	localparam int ORDER_W    = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// multiplier split of the accumulator
	localparam int MUL_LO_W = 24;
	localparam int MUL_HI_W = ACC_W - MUL_LO_W;
	localparam int PROD_W   = ACC_W + X_W;
	localparam int RND_W    = PROD_W - FRAC_W;
	localparam int SUM_W    = RND_W + 1;

	// cycles through one horner step
	localparam int STEP_LAT = 3;

	// register indexes
	localparam int REG_POLY_ORDER = 0;
	localparam int REG_COEFF_BASE = 1;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef struct packed {
		logic                    valid;
		logic                    clip;
		logic signed [X_W-1:0]   x;
		logic signed [ACC_W-1:0] val;
		logic signed [ACC_W-1:0] slo;
		logic signed [ACC_W-1:0] cur;
	} pvd_bus_t;

endpackage

// ----- src/pvd_cfg.sv -----
// ----------------------------------------------------------------------------
// pvd_cfg
// Configuration registers; keeps the coefficients together with their first
// and second derivative weights and hands out the weights masked by order.
// ----------------------------------------------------------------------------
module pvd_cfg import pvd_pkg::*; #(
	parameter int COEFF_COUNT = COEFF_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_wdata,
	output logic signed [ACC_W-1:0]      w_val [COEFF_COUNT],
	output logic signed [ACC_W-1:0]      w_slo [COEFF_COUNT],
	output logic signed [ACC_W-1:0]      w_cur [COEFF_COUNT],
	output logic [ORDER_W-1:0]           eff_order
);

	localparam int K  = COEFF_COUNT - 1;
	localparam int WS = COEF_W + $clog2(COEFF_COUNT);
	localparam int WC = COEF_W + $clog2(K * (K - 1) + 1);

	logic [ORDER_W-1:0]        order_q;
	logic signed [COEF_W-1:0]  coef_q  [COEFF_COUNT];
	logic signed [WS-1:0]      slope_q [COEFF_COUNT];
	logic signed [WC-1:0]      curv_q  [COEFF_COUNT];

	// derivative weights k*c and k*(k-1)*c are formed at write time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= '0;
			for (int k = 0; k < COEFF_COUNT; k++) begin
				coef_q[k]  <= '0;
				slope_q[k] <= '0;
				curv_q[k]  <= '0;
			end
		end else if (cfg_wr_en) begin
			if (cfg_index == CFG_IDX_W'(REG_POLY_ORDER)) begin
				order_q <= cfg_wdata[ORDER_W-1:0];
			end
			for (int k = 0; k < COEFF_COUNT; k++) begin
				if (cfg_index == CFG_IDX_W'(REG_COEFF_BASE + k)) begin
					coef_q[k]  <= cfg_wdata[COEF_W-1:0];
					slope_q[k] <= WS'($signed(cfg_wdata[COEF_W-1:0])) * WS'(k);
					curv_q[k]  <= WC'($signed(cfg_wdata[COEF_W-1:0])) * WC'(k * (k - 1));
				end
			end
		end
	end

	assign eff_order = (order_q > ORDER_W'(K)) ? ORDER_W'(K) : order_q;

	// weight i of each chain uses coefficient k = i, i+1, i+2; zero above the order
	for (genvar i = 0; i < COEFF_COUNT; i++) begin : g_wt
		assign w_val[i] = (ORDER_W'(i) <= eff_order) ? ACC_W'(coef_q[i]) : '0;
		if (i + 1 <= K) begin : g_slo
			assign w_slo[i] = (ORDER_W'(i + 1) <= eff_order) ? ACC_W'(slope_q[i + 1]) : '0;
		end else begin : g_slo_zero
			assign w_slo[i] = '0;
		end
		if (i + 2 <= K) begin : g_cur
			assign w_cur[i] = (ORDER_W'(i + 2) <= eff_order) ? ACC_W'(curv_q[i + 2]) : '0;
		end else begin : g_cur_zero
			assign w_cur[i] = '0;
		end
	end

endmodule

// ----- src/pvd_mac.sv -----
// ----------------------------------------------------------------------------
// pvd_mac
// One horner step of one chain in three stages: split multiply, round, then
// add weight and saturate to Q32.16.
// ----------------------------------------------------------------------------
module pvd_mac import pvd_pkg::*; (
	input  logic                    clk,
	input  logic signed [ACC_W-1:0] acc_in,
	input  logic signed [X_W-1:0]   x,
	input  logic signed [ACC_W-1:0] wt,
	output logic signed [ACC_W-1:0] acc_out,
	output logic                    sat
);

	localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (FRAC_W - 1);

	logic signed [MUL_LO_W+X_W:0]   plo_s1;
	logic signed [MUL_HI_W+X_W-1:0] phi_s1;
	logic signed [RND_W-1:0]        rnd_s2;
	logic signed [ACC_W-1:0]        acc_s3;
	logic                           sat_s3;

	logic signed [PROD_W-1:0] full;
	logic signed [SUM_W-1:0]  sum;
	logic                     in_range;

	always_ff @(posedge clk) begin
		plo_s1 <= $signed({1'b0, acc_in[MUL_LO_W-1:0]}) * x;
		phi_s1 <= $signed(acc_in[ACC_W-1:MUL_LO_W]) * x;
	end

	// exact product plus half an lsb, then floor to 16 fraction bits
	always_comb begin
		full = (PROD_W'(phi_s1) <<< MUL_LO_W) + PROD_W'(plo_s1) + RND_HALF;
	end

	always_ff @(posedge clk) begin
		rnd_s2 <= full[PROD_W-1:FRAC_W];
	end

	always_comb begin
		sum      = SUM_W'(rnd_s2) + SUM_W'(wt);
		in_range = (&sum[SUM_W-1:ACC_W-1]) | ~(|sum[SUM_W-1:ACC_W-1]);
	end

	always_ff @(posedge clk) begin
		if (in_range) begin
			acc_s3 <= sum[ACC_W-1:0];
		end else if (sum[SUM_W-1]) begin
			acc_s3 <= ACC_MIN;
		end else begin
			acc_s3 <= ACC_MAX;
		end
		sat_s3 <= ~in_range;
	end

	assign acc_out = acc_s3;
	assign sat     = sat_s3;

endmodule

// ----- src/pvd_step.sv -----
// ----------------------------------------------------------------------------
// pvd_step
// One horner step for the value, slope and curvature chains side by side,
// with the request's valid bit, abscissa and clip flag carried alongside.
// ----------------------------------------------------------------------------
module pvd_step import pvd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pvd_bus_t                bus_i,
	input  logic signed [ACC_W-1:0] wt_val,
	input  logic signed [ACC_W-1:0] wt_slo,
	input  logic signed [ACC_W-1:0] wt_cur,
	output pvd_bus_t                bus_o
);

	logic                  valid_s1, valid_s2, valid_s3;
	logic signed [X_W-1:0] x_s1, x_s2, x_s3;
	logic                  clip_s1, clip_s2, clip_s3;

	logic signed [ACC_W-1:0] val_acc, slo_acc, cur_acc;
	logic                    val_sat, slo_sat, cur_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= bus_i.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= bus_i.x;
		x_s2    <= x_s1;
		x_s3    <= x_s2;
		clip_s1 <= bus_i.clip;
		clip_s2 <= clip_s1;
		clip_s3 <= clip_s2;
	end

	pvd_mac u_mac_val (
		.clk     (clk),
		.acc_in  (bus_i.val),
		.x       (bus_i.x),
		.wt      (wt_val),
		.acc_out (val_acc),
		.sat     (val_sat)
	);

	pvd_mac u_mac_slo (
		.clk     (clk),
		.acc_in  (bus_i.slo),
		.x       (bus_i.x),
		.wt      (wt_slo),
		.acc_out (slo_acc),
		.sat     (slo_sat)
	);

	pvd_mac u_mac_cur (
		.clk     (clk),
		.acc_in  (bus_i.cur),
		.x       (bus_i.x),
		.wt      (wt_cur),
		.acc_out (cur_acc),
		.sat     (cur_sat)
	);

	always_comb begin
		bus_o.valid = valid_s3;
		bus_o.clip  = clip_s3 | val_sat | slo_sat | cur_sat;
		bus_o.x     = x_s3;
		bus_o.val   = val_acc;
		bus_o.slo   = slo_acc;
		bus_o.cur   = cur_acc;
	end

endmodule

// ----- src/poly_value_and_derivatives_unit.sv -----
// ----------------------------------------------------------------------------
// poly_value_and_derivatives_unit
// Evaluates p(x), p'(x) and p''(x) of a configured polynomial of order 0..5
// with Q16.16 coefficients; Q32.16 results saturate and set clipped.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload
//  -------   ----------------   ---------------------------------------
//  request   start / busy       abscissa
//  result    done (strobe)      value, slope, curvature, clipped
//  config    cfg_wr_en          cfg_index, cfg_wdata
//
//  a request is taken on every clock edge with start high and busy low; one
//  per cycle is sustained.
//  a request passes one input stage, then one three-stage multiply/round/saturate
//  step per power.
//  results leave with done for one cycle; the receiver cannot stall.
//  busy is high during reset and until the first clock edge after its release.
//
module poly_value_and_derivatives_unit import pvd_pkg::*; #(
	parameter int COEFF_COUNT = COEFF_COUNT_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [X_W-1:0]   abscissa,
	output logic                    done,
	output logic signed [ACC_W-1:0] value,
	output logic signed [ACC_W-1:0] slope,
	output logic signed [ACC_W-1:0] curvature,
	output logic                    clipped,
	input  logic                    cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int K   = COEFF_COUNT - 1;
	localparam int LAT = STEP_LAT * K + 1;

	logic signed [ACC_W-1:0] w_val [COEFF_COUNT];
	logic signed [ACC_W-1:0] w_slo [COEFF_COUNT];
	logic signed [ACC_W-1:0] w_cur [COEFF_COUNT];
	logic [ORDER_W-1:0]      eff_order;

	logic                  busy_q;
	logic                  valid_s0;
	logic signed [X_W-1:0] x_s0;
	logic                  accept;

	pvd_bus_t bus [COEFF_COUNT];

	pvd_cfg #(
		.COEFF_COUNT (COEFF_COUNT)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.w_val     (w_val),
		.w_slo     (w_slo),
		.w_cur     (w_cur),
		.eff_order (eff_order)
	);

	assign accept = start & ~busy_q;
	assign busy   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b1;
			valid_s0 <= 1'b0;
		end else begin
			busy_q   <= 1'b0;
			valid_s0 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		x_s0 <= abscissa;
	end

	// chains start from their top weight; weights above the order are zero
	always_comb begin
		bus[0].valid = valid_s0;
		bus[0].clip  = 1'b0;
		bus[0].x     = x_s0;
		bus[0].val   = w_val[K];
		bus[0].slo   = w_slo[K];
		bus[0].cur   = w_cur[K];
	end

	for (genvar j = 0; j < K; j++) begin : g_step
		pvd_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.bus_i  (bus[j]),
			.wt_val (w_val[K-1-j]),
			.wt_slo (w_slo[K-1-j]),
			.wt_cur (w_cur[K-1-j]),
			.bus_o  (bus[j+1])
		);
	end

	assign done      = bus[K].valid;
	assign value     = bus[K].val;
	assign slope     = bus[K].slo;
	assign curvature = bus[K].cur;
	assign clipped   = bus[K].clip;

	// every result traces back to a request a fixed latency earlier
	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching request");

	a_order0_slope: assert property (@(posedge clk) disable iff (!arst_n)
		(done && eff_order == '0) |-> (slope == '0 && curvature == '0))
		else $error("derivatives nonzero at order zero");

	a_order1_curv: assert property (@(posedge clk) disable iff (!arst_n)
		(done && eff_order < ORDER_W'(2)) |-> (curvature == '0))
		else $error("curvature nonzero below order two");

	a_no_request_in_reset_guard: assert property (@(posedge clk) disable iff (!arst_n)
		$past(busy) |-> !valid_s0)
		else $error("request taken while busy");

endmodule
